/* rtl/qrs_pkg.sv */
// Shared constants, state encoding and helper functions for the QRS peak detector.
`default_nettype none
package qrs_pkg;

  localparam int WINDOW_MAX_DEF    = 64;
  localparam int HISTORY_DEPTH_DEF = 512;
  localparam int RR_DEPTH_DEF      = 8;

  localparam int CFG_W = 15;

  localparam logic [1:0] REG_REFRACTORY = 2'd0;
  localparam logic [1:0] REG_TWAVE      = 2'd1;
  localparam logic [1:0] REG_WINDOW     = 2'd2;
  localparam logic [1:0] REG_DC_POLE    = 2'd3;

  localparam logic [9:0]  REFRACTORY_RESET = 10'd72;
  localparam logic [9:0]  TWAVE_RESET      = 10'd129;
  localparam int          WINDOW_RESET     = 54;
  localparam logic [14:0] DC_POLE_RESET    = 15'd32604;

  localparam logic [10:0] Q10_LOW  = 11'd942;
  localparam logic [10:0] Q10_HIGH = 11'd1188;
  localparam logic [10:0] Q10_MISS = 11'd1700;

  localparam logic [61:0] ENERGY_MAX = 62'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] FILL_MAX   = 16'hFFFF;

  localparam logic signed [39:0] S32_MAX = 40'sd2147483647;
  localparam logic signed [39:0] S32_MIN = -40'sd2147483648;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_MUL   = 19'h00002,
    S_DC    = 19'h00004,
    S_LP    = 19'h00008,
    S_HP    = 19'h00010,
    S_SLOPE = 19'h00020,
    S_SQ    = 19'h00040,
    S_SUM   = 19'h00080,
    S_DIV   = 19'h00100,
    S_HWR   = 19'h00200,
    S_DET   = 19'h00400,
    S_SBSET = 19'h00800,
    S_SCAN  = 19'h01000,
    S_LVL   = 19'h02000,
    S_THR   = 19'h04000,
    S_REC1  = 19'h08000,
    S_REC2  = 19'h10000,
    S_REC3  = 19'h20000,
    S_DONE  = 19'h40000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [15:0] limit_q10(input logic [15:0] avg, input logic [10:0] q);
    logic [26:0] p;
    p = 27'(avg) * 27'(q);
    return p[26] ? 16'hFFFF : p[25:10];
  endfunction

endpackage
`default_nettype wire

/* rtl/qrs_peak_detector.sv */
// QRS peak detector: filter chain, window integrator, adaptive thresholds and search-back.
`default_nettype none
// One ECG sample per transaction, one result per sample. Each sample runs through a
// sequencer: S_IDLE takes the sample in, S_MUL to S_SQ filter and square it, S_SUM
// sums the integration window out of its memory over cnt entries (cnt = active window
// length), S_DIV runs a bit-serial division for the window mean, then S_HWR to S_REC3
// write the history and do the detection, threshold and RR bookkeeping. A search-back
// scans one history entry per cycle, up to HISTORY_DEPTH-1 entries; the single read
// port of the history memory sets that rate.
// The window and history memories need no clearing after reset, so a sample is taken
// from the first cycle after reset. A finished result is held in the output register
// while the next sample is taken in.
module qrs_peak_detector #(
  parameter int WINDOW_MAX    = qrs_pkg::WINDOW_MAX_DEF,
  parameter int HISTORY_DEPTH = qrs_pkg::HISTORY_DEPTH_DEF,
  parameter int RR_DEPTH      = qrs_pkg::RR_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [15:0]        ecg_sample,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [qrs_pkg::CFG_W-1:0] cfg_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        lowpass_out,
  output logic signed [31:0]        highpass_out,
  output logic signed [31:0]        slope_out,
  output logic [61:0]               energy_out,
  output logic [61:0]               window_mean,
  output logic                      beat_found,
  output logic [8:0]                beat_offset,
  output logic [15:0]               rr_interval,
  output logic                      rhythm_regular
);

  localparam int WL_W   = $clog2(WINDOW_MAX + 1);
  localparam int EW_AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int HA_W   = $clog2(HISTORY_DEPTH);
  localparam int TOT_W  = 62 + WL_W;
  localparam int DV_CW  = $clog2(TOT_W + 1);
  localparam int RR_SH  = $clog2(RR_DEPTH);
  localparam int RS_W   = 16 + RR_SH;
  localparam int HIST_W = 62 + 32 + 62;
  localparam int WL_RST = (qrs_pkg::WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                               : qrs_pkg::WINDOW_RESET;

  qrs_pkg::state_t state;

  // configuration
  logic [9:0]      refractory;
  logic [9:0]      twave_limit;
  logic [WL_W-1:0] win_len;
  logic [14:0]     dc_pole;

  // filter state
  logic signed [15:0] x_r, prev_sample;
  logic signed [31:0] dc_dl [0:11];
  logic signed [31:0] lp_dl [0:31];
  logic signed [31:0] hp_prev;
  logic [15:0]        fill_count;
  logic [31:0]        sample_count, last_beat;
  logic [61:0]        last_energy;
  logic               regular;

  // levels and thresholds
  logic signed [63:0] spk_i, spk_f, npk_i, npk_f, thr_i1, thr_i2, thr_f1, thr_f2;

  // RR tables
  logic [15:0] rr_recent [0:RR_DEPTH-1];
  logic [15:0] rr_sel    [0:RR_DEPTH-1];
  logic [15:0] lim_low, lim_high, lim_miss;

  // per-sample working registers
  logic [46:0]        fb_prod;
  logic               fb_neg;
  logic signed [31:0] dc_v, lp_v, hp_v, slope_v;
  logic [61:0]        energy_v, mean_v;
  logic [WL_W-1:0]    cnt, sum_j, dv_r;
  logic [TOT_W-1:0]   total, dv_q;
  logic [DV_CW-1:0]   dv_n;
  logic               upd_sig, upd_sh2, do_rec, nz_pend, sel_upd, beat_r;
  logic signed [63:0] pk_i, pk_f;
  logic [31:0]        rec_pos;
  logic [8:0]         offset_r;
  logic [15:0]        avg1, avg2;

  // energy window memory
  logic [61:0]      ew_mem [0:WINDOW_MAX-1];
  logic [EW_AW-1:0] ew_ptr, ew_rp, ew_nx;
  logic [61:0]      ew_q;

  // history memory: {mean, band, energy}
  logic [HIST_W-1:0] hist_mem [0:HISTORY_DEPTH-1];
  logic [HA_W-1:0]   hist_wp, hist_nx, sb_addr, sb_k, sb_k_d;
  logic [HIST_W-1:0] hist_q;
  logic              sb_v;

  // combinational helpers
  logic [31:0]        dmag, fb, smag, el, d_rr, avail, top, el_m1;
  logic [63:0]        sq;
  logic [61:0]        energy_c, half_e, h_mean, h_energy;
  logic signed [31:0] h_band;
  logic [15:0]        fill_inc, rr_c;
  logic signed [63:0] i_s, f_s, thr_i1_c, thr_f1_c, sh_sig_i, sh_sig_f;
  logic               ge_i, ge_f, tw_ok, miss_go, hit, sel_ok, r_ge;
  logic [WL_W:0]      r_sh;
  logic [RS_W-1:0]    sum1, sum2;
  logic [6:0]         wv;
  logic [WL_W-1:0]    wv_clamp;

  assign in_stall = (state != qrs_pkg::S_IDLE);

  always_comb begin
    dmag     = dc_dl[0][31] ? (~dc_dl[0] + 32'd1) : dc_dl[0];
    fb       = fb_prod[46:15];
    smag     = slope_v[31] ? (~slope_v + 32'd1) : slope_v;
    sq       = 64'(smag) * 64'(smag);
    energy_c = (sq > 64'(qrs_pkg::ENERGY_MAX)) ? qrs_pkg::ENERGY_MAX : sq[61:0];
    ew_nx    = (ew_ptr == EW_AW'(WINDOW_MAX - 1)) ? '0 : ew_ptr + 1'b1;
    hist_nx  = (hist_wp == HA_W'(HISTORY_DEPTH - 1)) ? '0 : hist_wp + 1'b1;
    fill_inc = (fill_count == qrs_pkg::FILL_MAX) ? fill_count : fill_count + 16'd1;

    r_sh = {dv_r, dv_q[TOT_W-1]};
    r_ge = r_sh >= {1'b0, cnt};

    el     = sample_count - last_beat;
    i_s    = $signed({2'b00, mean_v});
    f_s    = 64'(hp_v);
    ge_i   = i_s >= thr_i1;
    ge_f   = f_s >= thr_f1;
    half_e = last_energy >> 1;
    tw_ok  = (el <= 32'(twave_limit)) ? (energy_v >= half_e) : (energy_v > half_e);
    miss_go = (lim_miss != 16'd0) && (el > 32'(lim_miss));

    avail = (32'(fill_count) - 32'd1 > 32'(HISTORY_DEPTH - 1)) ? 32'(HISTORY_DEPTH - 1)
                                                                : 32'(fill_count) - 32'd1;
    el_m1 = el - 32'd1;
    top   = (el_m1 > avail) ? avail : el_m1;

    h_mean   = hist_q[HIST_W-1 -: 62];
    h_band   = hist_q[93:62];
    h_energy = hist_q[61:0];
    hit      = ($signed({2'b00, h_mean}) > thr_i2) && (64'(h_band) > thr_f2);

    sh_sig_i = upd_sh2 ? ((pk_i - spk_i) >>> 2) : ((pk_i - spk_i) >>> 3);
    sh_sig_f = upd_sh2 ? ((pk_f - spk_f) >>> 2) : ((pk_f - spk_f) >>> 3);
    thr_i1_c = npk_i + ((spk_i - npk_i) >>> 2);
    thr_f1_c = npk_f + ((spk_f - npk_f) >>> 2);

    d_rr   = rec_pos - last_beat;
    rr_c   = (d_rr > 32'd65535) ? 16'hFFFF : d_rr[15:0];
    sel_ok = (lim_high == 16'd0) || ((rr_c >= lim_low) && (rr_c <= lim_high));

    sum1 = '0;
    sum2 = '0;
    for (int k = 0; k < RR_DEPTH; k++) begin
      sum1 = sum1 + RS_W'(rr_recent[k]);
      sum2 = sum2 + RS_W'(rr_sel[k]);
    end

    wv = cfg_data[6:0];
    if (wv == 7'd0) wv_clamp = WL_W'(1);
    else if (32'(wv) > 32'(WINDOW_MAX)) wv_clamp = WL_W'(WINDOW_MAX);
    else wv_clamp = WL_W'(wv);
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (state == qrs_pkg::S_SQ) ew_mem[ew_nx] <= energy_c;
    ew_q <= ew_mem[ew_rp];
    if (state == qrs_pkg::S_HWR) hist_mem[hist_nx] <= {dv_q[61:0], hp_v, energy_v};
    hist_q <= hist_mem[sb_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= qrs_pkg::S_IDLE;
      refractory   <= qrs_pkg::REFRACTORY_RESET;
      twave_limit  <= qrs_pkg::TWAVE_RESET;
      win_len      <= WL_W'(WL_RST);
      dc_pole      <= qrs_pkg::DC_POLE_RESET;
      prev_sample  <= '0;
      for (int k = 0; k < 12; k++) dc_dl[k] <= '0;
      for (int k = 0; k < 32; k++) lp_dl[k] <= '0;
      hp_prev      <= '0;
      fill_count   <= '0;
      sample_count <= '0;
      last_beat    <= '0;
      last_energy  <= '0;
      regular      <= 1'b1;
      spk_i  <= '0; spk_f  <= '0; npk_i  <= '0; npk_f  <= '0;
      thr_i1 <= '0; thr_i2 <= '0; thr_f1 <= '0; thr_f2 <= '0;
      for (int k = 0; k < RR_DEPTH; k++) begin
        rr_recent[k] <= '0;
        rr_sel[k]    <= '0;
      end
      lim_low   <= '0;
      lim_high  <= '0;
      lim_miss  <= '0;
      ew_ptr    <= '0;
      ew_rp     <= '0;
      hist_wp   <= '0;
      sb_addr   <= '0;
      sb_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          qrs_pkg::REG_REFRACTORY: refractory  <= cfg_data[9:0];
          qrs_pkg::REG_TWAVE:      twave_limit <= cfg_data[9:0];
          qrs_pkg::REG_WINDOW:     win_len     <= wv_clamp;
          qrs_pkg::REG_DC_POLE:    dc_pole     <= cfg_data[14:0];
          default: ;
        endcase
      end

      // a result loaded in S_DONE sets out_valid itself
      if (out_valid && !out_stall && state != qrs_pkg::S_DONE) out_valid <= 1'b0;

      case (state)
        qrs_pkg::S_IDLE: begin
          if (in_valid) begin
            x_r      <= ecg_sample;
            beat_r   <= 1'b0;
            offset_r <= '0;
            state    <= qrs_pkg::S_MUL;
          end
        end
        qrs_pkg::S_MUL: begin
          fb_prod <= 47'(dmag) * 47'(dc_pole);
          fb_neg  <= dc_dl[0][31];
          state   <= qrs_pkg::S_DC;
        end
        qrs_pkg::S_DC: begin
          if (fill_count == 16'd0) dc_v <= '0;
          else dc_v <= qrs_pkg::sat32(40'(x_r) - 40'(prev_sample)
                                      + (fb_neg ? -$signed({8'b0, fb}) : $signed({8'b0, fb})));
          state <= qrs_pkg::S_LP;
        end
        qrs_pkg::S_LP: begin
          lp_v  <= qrs_pkg::sat32(40'(dc_v) + (40'(lp_dl[0]) <<< 1) - 40'(lp_dl[1])
                                  - (40'(dc_dl[5]) <<< 1) + 40'(dc_dl[11]));
          state <= qrs_pkg::S_HP;
        end
        qrs_pkg::S_HP: begin
          hp_v  <= qrs_pkg::sat32((40'(lp_dl[15]) <<< 5) + 40'(lp_dl[31])
                                  - 40'(lp_v) - 40'(hp_prev));
          state <= qrs_pkg::S_SLOPE;
        end
        qrs_pkg::S_SLOPE: begin
          slope_v <= qrs_pkg::sat32(40'(hp_v) - 40'(hp_prev));
          state   <= qrs_pkg::S_SQ;
        end
        qrs_pkg::S_SQ: begin
          energy_v <= energy_c;
          ew_ptr   <= ew_nx;
          ew_rp    <= ew_nx;
          dc_dl[0] <= dc_v;
          for (int k = 1; k < 12; k++) dc_dl[k] <= dc_dl[k-1];
          lp_dl[0] <= lp_v;
          for (int k = 1; k < 32; k++) lp_dl[k] <= lp_dl[k-1];
          hp_prev      <= hp_v;
          prev_sample  <= x_r;
          fill_count   <= fill_inc;
          sample_count <= sample_count + 32'd1;
          cnt   <= (16'(win_len) < fill_inc) ? win_len : WL_W'(fill_inc);
          sum_j <= '0;
          total <= '0;
          state <= qrs_pkg::S_SUM;
        end
        qrs_pkg::S_SUM: begin
          // read newest first; data arrives in the cycle after its address
          if (sum_j == cnt) begin
            dv_q  <= total + TOT_W'(ew_q);
            dv_r  <= '0;
            dv_n  <= '0;
            state <= qrs_pkg::S_DIV;
          end else begin
            if (sum_j != '0) total <= total + TOT_W'(ew_q);
            ew_rp <= (ew_rp == '0) ? EW_AW'(WINDOW_MAX - 1) : ew_rp - 1'b1;
            sum_j <= sum_j + 1'b1;
          end
        end
        qrs_pkg::S_DIV: begin
          dv_r <= r_ge ? WL_W'(r_sh - {1'b0, cnt}) : r_sh[WL_W-1:0];
          dv_q <= {dv_q[TOT_W-2:0], r_ge};
          dv_n <= dv_n + 1'b1;
          if (dv_n == DV_CW'(TOT_W - 1)) state <= qrs_pkg::S_HWR;
        end
        qrs_pkg::S_HWR: begin
          mean_v  <= dv_q[61:0];
          hist_wp <= hist_nx;
          state   <= qrs_pkg::S_DET;
        end
        qrs_pkg::S_DET: begin
          pk_i    <= i_s;
          pk_f    <= f_s;
          upd_sh2 <= 1'b0;
          do_rec  <= 1'b0;
          if (ge_i && ge_f && (el <= 32'(refractory))) begin
            upd_sig <= 1'b0;
            state   <= qrs_pkg::S_LVL;
          end else if (ge_i && ge_f && tw_ok) begin
            upd_sig     <= 1'b1;
            do_rec      <= 1'b1;
            last_energy <= energy_v;
            rec_pos     <= sample_count;
            beat_r      <= 1'b1;
            state       <= qrs_pkg::S_LVL;
          end else if (miss_go) begin
            nz_pend <= ge_i || ge_f;
            state   <= qrs_pkg::S_SBSET;
          end else if (ge_i || ge_f) begin
            upd_sig <= 1'b0;
            state   <= qrs_pkg::S_LVL;
          end else begin
            state <= qrs_pkg::S_DONE;
          end
        end
        qrs_pkg::S_SBSET: begin
          sb_k    <= HA_W'(top);
          sb_addr <= (top > 32'(hist_wp)) ? HA_W'(32'(hist_wp) + 32'(HISTORY_DEPTH) - top)
                                          : HA_W'(32'(hist_wp) - top);
          sb_v    <= 1'b0;
          upd_sig <= 1'b0;
          if (top == 32'd0) state <= nz_pend ? qrs_pkg::S_LVL : qrs_pkg::S_DONE;
          else state <= qrs_pkg::S_SCAN;
        end
        qrs_pkg::S_SCAN: begin
          // oldest first: issue one address a cycle, test the entry read last cycle
          if (sb_v && hit) begin
            upd_sig     <= 1'b1;
            upd_sh2     <= 1'b1;
            do_rec      <= 1'b1;
            pk_i        <= $signed({2'b00, h_mean});
            pk_f        <= 64'(h_band);
            last_energy <= h_energy;
            beat_r      <= 1'b1;
            offset_r    <= 9'(sb_k_d);
            rec_pos     <= sample_count - 32'(sb_k_d);
            sb_v        <= 1'b0;
            state       <= qrs_pkg::S_LVL;
          end else if (sb_v && (sb_k_d == HA_W'(1))) begin
            sb_v  <= 1'b0;
            state <= nz_pend ? qrs_pkg::S_LVL : qrs_pkg::S_DONE;
          end else begin
            sb_v   <= (sb_k != '0);
            sb_k_d <= sb_k;
            if (sb_k != '0) begin
              sb_k    <= sb_k - 1'b1;
              sb_addr <= (sb_addr == HA_W'(HISTORY_DEPTH - 1)) ? '0 : sb_addr + 1'b1;
            end
          end
        end
        qrs_pkg::S_LVL: begin
          if (upd_sig) begin
            spk_i <= spk_i + sh_sig_i;
            spk_f <= spk_f + sh_sig_f;
          end else begin
            npk_i <= npk_i + ((pk_i - npk_i) >>> 3);
            npk_f <= npk_f + ((pk_f - npk_f) >>> 3);
          end
          state <= qrs_pkg::S_THR;
        end
        qrs_pkg::S_THR: begin
          thr_i1 <= thr_i1_c;
          thr_i2 <= thr_i1_c >>> 1;
          thr_f1 <= thr_f1_c;
          thr_f2 <= thr_f1_c >>> 1;
          state  <= do_rec ? qrs_pkg::S_REC1 : qrs_pkg::S_DONE;
        end
        qrs_pkg::S_REC1: begin
          last_beat <= rec_pos;
          for (int k = 0; k < RR_DEPTH - 1; k++) rr_recent[k] <= rr_recent[k+1];
          rr_recent[RR_DEPTH-1] <= rr_c;
          if (sel_ok) begin
            for (int k = 0; k < RR_DEPTH - 1; k++) rr_sel[k] <= rr_sel[k+1];
            rr_sel[RR_DEPTH-1] <= rr_c;
          end
          sel_upd <= sel_ok;
          state   <= qrs_pkg::S_REC2;
        end
        qrs_pkg::S_REC2: begin
          avg1  <= 16'(sum1 >> RR_SH);
          avg2  <= 16'(sum2 >> RR_SH);
          state <= qrs_pkg::S_REC3;
        end
        qrs_pkg::S_REC3: begin
          if (sel_upd) begin
            lim_low  <= qrs_pkg::limit_q10(avg2, qrs_pkg::Q10_LOW);
            lim_high <= qrs_pkg::limit_q10(avg2, qrs_pkg::Q10_HIGH);
            lim_miss <= qrs_pkg::limit_q10(avg2, qrs_pkg::Q10_MISS);
          end
          if (avg1 == avg2) begin
            regular <= 1'b1;
          end else begin
            // entering irregular rhythm: halve the primary thresholds
            if (regular) begin
              thr_i1 <= thr_i1 >>> 1;
              thr_f1 <= thr_f1 >>> 1;
            end
            regular <= 1'b0;
          end
          state <= qrs_pkg::S_DONE;
        end
        qrs_pkg::S_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            lowpass_out    <= lp_v;
            highpass_out   <= hp_v;
            slope_out      <= slope_v;
            energy_out     <= energy_v;
            window_mean    <= mean_v;
            beat_found     <= beat_r;
            beat_offset    <= offset_r;
            rr_interval    <= rr_recent[RR_DEPTH-1];
            rhythm_regular <= regular;
            out_valid      <= 1'b1;
            state          <= qrs_pkg::S_IDLE;
          end
        end
        default: state <= qrs_pkg::S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
